>>> rtl/tdpt_pkg.sv
// Package for the trial division prime test: shared types and constants.
package tdpt_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [1:0] {
      CLASS_COMPOSITE = 2'd0,
      CLASS_PRIME     = 2'd1,
      CLASS_TEST      = 2'd2
   } class_type;

   localparam int CLASS_WIDTH = $bits(class_type);

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/tdpt_front.sv
// Front end: classifies each accepted candidate and pushes it to the queue.
module tdpt_front
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   input  queue_status_type       queue_status,
   output logic                   busy,
   output logic                   push,
   output logic [VALUE_WIDTH-1:0] push_value,
   output class_type              push_class
);

   localparam logic [VALUE_WIDTH-1:0] TWO   = VALUE_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] THREE = VALUE_WIDTH'(3);

   assign busy       = queue_status.full;
   assign push       = start && !queue_status.full;
   assign push_value = req_candidate;

   // 0 and 1 are not prime, 2 and 3 are, even values above 3 are composite.
   // Only odd values of 5 and up need the divisor search.
   always_comb begin
      if (req_candidate < TWO) begin
         push_class = CLASS_COMPOSITE;
      end else if (req_candidate <= THREE) begin
         push_class = CLASS_PRIME;
      end else if (!req_candidate[0]) begin
         push_class = CLASS_COMPOSITE;
      end else begin
         push_class = CLASS_TEST;
      end
   end

endmodule

>>> rtl/tdpt_queue.sv
// Short FIFO between the classifier and the divisor search.
module tdpt_queue
   import tdpt_pkg::*;
#(
   parameter int WIDTH = DEFAULT_VALUE_WIDTH + CLASS_WIDTH,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/tdpt_back.sv
// Back end: odd divisor search with a bit-serial remainder unit.
module tdpt_back
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       queue_status,
   input  logic [VALUE_WIDTH-1:0] head_value,
   input  class_type              head_class,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic                   rsp_is_prime
);

   localparam int W     = VALUE_WIDTH;
   localparam int SQ_W  = W + 2;
   localparam int BIT_W = $clog2(W);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BOUND = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_TEST  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [W-1:0]     n_ff, n_in;
   logic [W-1:0]     d_ff, d_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;     // d squared, kept by adds
   logic [W-1:0]     rem_ff, rem_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             valid_ff, valid_in;
   logic             prime_ff, prime_in;

   logic [W:0]       rem_shift;
   logic [W:0]       d_ext;

   assign rem_shift = {rem_ff, n_ff[bit_ff]};
   assign d_ext     = {1'b0, d_ff};

   assign pop          = (state_ff == ST_IDLE) && !queue_status.empty;
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      valid_in = 1'b0;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               case (head_class)
                  CLASS_PRIME: begin
                     valid_in = 1'b1;
                     prime_in = 1'b1;
                  end
                  CLASS_TEST: begin
                     n_in     = head_value;
                     d_in     = W'(3);
                     sq_in    = SQ_W'(9);
                     state_in = ST_BOUND;
                  end
                  default: begin
                     valid_in = 1'b1;
                     prime_in = 1'b0;
                  end
               endcase
            end
         end
         ST_BOUND: begin
            // past the square root with no divisor found: prime
            if (sq_ff > {2'b00, n_ff}) begin
               valid_in = 1'b1;
               prime_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rem_in   = '0;
               bit_in   = BIT_W'(W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit per cycle, MSB first
            if (rem_shift >= d_ext) begin
               rem_in = W'(rem_shift - d_ext);
            end else begin
               rem_in = W'(rem_shift);
            end
            if (bit_ff == '0) begin
               state_in = ST_TEST;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_TEST: begin
            if (rem_ff == '0) begin
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               // (d+2)^2 = d^2 + 4d + 4
               d_in     = d_ff + W'(2);
               sq_in    = sq_ff + {d_ff, 2'b00} + SQ_W'(4);
               state_in = ST_BOUND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      prime_ff <= prime_in;
   end

endmodule

>>> rtl/trial_division_prime_test.sv
// Top level of the trial division prime test.
//
//   channel   ports                        beat taken when
//   --------  ---------------------------  -----------------------------
//   request   start, busy, req_candidate   start && !busy at clock edge
//   response  rsp_valid, rsp_is_prime      rsp_valid high, one cycle only
//
// Flow: a request beat lands in a short queue in the same cycle. The back
// end takes one queued value at a time. 0, 1, 2, 3 and even values answer
// in the cycle after they are taken from the queue. Odd values of 5 and up
// run the odd divisors d = 3, 5, 7 and so on while d*d <= n; each divisor
// passes a bound check, VALUE_WIDTH bit-serial remainder steps and a zero
// test, and the remainder loop handles one dividend bit per cycle.
// Reset: synchronous, active high; clears the queue and the search control.
// Stalls: busy rises only while the queue is full. The receiver cannot
// stall; each response beat is shown for exactly one cycle, in request order.
module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                   rsp_valid,
   output logic                   rsp_is_prime
);

   localparam int ENTRY_W = VALUE_WIDTH + CLASS_WIDTH;

   queue_status_type       queue_status;
   logic                   push;
   logic [VALUE_WIDTH-1:0] push_value;
   class_type              push_class;
   logic                   pop;
   logic [ENTRY_W-1:0]     head_data;
   logic [VALUE_WIDTH-1:0] head_value;
   class_type              head_class;

   // classify on the way in
   tdpt_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .start         (start),
      .req_candidate (req_candidate),
      .queue_status  (queue_status),
      .busy          (busy),
      .push          (push),
      .push_value    (push_value),
      .push_class    (push_class)
   );

   // queue entry: value in the high bits, class code in the low bits
   tdpt_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_value, push_class}),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   assign head_value = head_data[ENTRY_W-1:CLASS_WIDTH];
   assign head_class = class_type'(head_data[CLASS_WIDTH-1:0]);

   // divisor search and response register
   tdpt_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_value   (head_value),
      .head_class   (head_class),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule
